@@ rtl/pidc_pkg.sv @@
// Package for the dual-form PID controller: register indexes, field widths,
// reset values and the configuration struct. Depends on nothing.
`default_nettype none

package pidc_pkg;

  // Fixed field widths of the register set
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned ILIM_W     = 31;
  localparam int unsigned OLIM_W     = 15;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned INTEG_W    = 32;
  localparam int unsigned HELD_W     = OLIM_W + 1;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned TUSER_W    = 2;

  // Flag positions in the result tuser
  localparam int unsigned TUSER_OUT_CLAMP = 0;
  localparam int unsigned TUSER_INT_CLAMP = 1;

  // Register indexes of the configuration port
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PROP_GAIN  = 4'd0,
    REG_INTEG_GAIN = 4'd1,
    REG_DERIV_GAIN = 4'd2,
    REG_INTEG_LIM  = 4'd3,
    REG_OUT_LIM    = 4'd4,
    REG_INCR_MODE  = 4'd5,
    REG_SEP_EN     = 4'd6,
    REG_SEP_THR    = 4'd7
  } cfg_reg_e;

  // Register reset values
  localparam logic [OLIM_W-1:0] OUT_LIM_RST = '1;
  localparam logic [THR_W-1:0]  SEP_THR_RST = '1;

  // Whole register set as seen by the datapath
  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [ILIM_W-1:0] integral_limit;
    logic [OLIM_W-1:0] output_limit;
    logic              incremental_mode;
    logic              separation_enable;
    logic [THR_W-1:0]  separation_threshold;
  } cfg_t;

endpackage

`default_nettype wire

@@ rtl/pidc_datapath.sv @@
// Combinational PID datapath: error, integral clamp, three gain products,
// fractional shift and output clamp for both forms. Depends on pidc_pkg.
`default_nettype none

module pidc_datapath #(
  parameter int unsigned DATA_WIDTH     = 16,
  parameter int unsigned GAIN_FRAC_BITS = 8
) (
  input  pidc_pkg::cfg_t                       cfg_i,
  input  logic signed [DATA_WIDTH-1:0]         setpoint_i,
  input  logic signed [DATA_WIDTH-1:0]         measurement_i,
  input  logic signed [DATA_WIDTH:0]           last_error_i,
  input  logic signed [DATA_WIDTH:0]           prev_error_i,
  input  logic signed [pidc_pkg::INTEG_W-1:0]  integral_i,
  input  logic signed [pidc_pkg::HELD_W-1:0]   held_i,
  output logic signed [DATA_WIDTH:0]           error_o,
  output logic signed [pidc_pkg::INTEG_W-1:0]  integral_o,
  output logic signed [pidc_pkg::HELD_W-1:0]   held_o,
  output logic [DATA_WIDTH-1:0]                drive_value_o,
  output logic                                 output_clamped_o,
  output logic                                 integral_clamped_o
);
  import pidc_pkg::*;

  localparam int unsigned EW = DATA_WIDTH + 1;
  localparam int unsigned OW = (EW + 2 > INTEG_W) ? EW + 2 : INTEG_W;
  localparam int unsigned PW = OW + GAIN_W + 1;
  localparam int unsigned AW = PW + 2;
  localparam int unsigned UW = AW + 1;
  localparam int unsigned SW = ((EW > INTEG_W) ? EW : INTEG_W) + 1;
  localparam int unsigned MW = (EW > THR_W) ? EW : THR_W;

  logic signed [EW-1:0]     err;
  logic signed [EW:0]       diff1;
  logic signed [EW+1:0]     diff2;
  logic [EW-1:0]            err_mag;
  logic                     sep_off;
  logic signed [SW-1:0]     sum_raw;
  logic [SW-1:0]            sum_mag;
  logic                     int_hit;
  logic signed [INTEG_W-1:0] sum_clamp;
  logic signed [OW-1:0]     op_p, op_i, op_d;
  logic [GAIN_W-1:0]        gain_i_eff;
  logic signed [PW-1:0]     prod_p, prod_i, prod_d;
  logic signed [AW-1:0]     acc, acc_sh;
  logic signed [UW-1:0]     u_raw;
  logic [UW-1:0]            u_mag;
  logic                     out_hit;
  logic signed [HELD_W-1:0] lim_s;
  logic signed [HELD_W-1:0] drive_full;

  // Error and its first and second differences
  assign err   = EW'(setpoint_i) - EW'(measurement_i);
  assign diff1 = (EW+1)'(err) - (EW+1)'(last_error_i);
  assign diff2 = (EW+2)'(err) - ((EW+2)'(last_error_i) <<< 1) + (EW+2)'(prev_error_i);

  // Integral separation on the error magnitude
  assign err_mag = err[EW-1] ? EW'(-err) : EW'(err);
  assign sep_off = cfg_i.separation_enable &&
                   (MW'(err_mag) > MW'(cfg_i.separation_threshold));

  // Positional integral with magnitude clamp; equality counts as a hit
  assign sum_raw = SW'(integral_i) + SW'(err);
  assign sum_mag = sum_raw[SW-1] ? SW'(-sum_raw) : SW'(sum_raw);
  assign int_hit = sum_mag >= SW'(cfg_i.integral_limit);
  always_comb begin
    if (!int_hit) begin
      sum_clamp = sum_raw[INTEG_W-1:0];
    end else if (sum_raw[SW-1]) begin
      sum_clamp = -$signed({1'b0, cfg_i.integral_limit});
    end else begin
      sum_clamp = $signed({1'b0, cfg_i.integral_limit});
    end
  end

  // Multiplier operands shared between the two forms
  assign op_p = cfg_i.incremental_mode ? OW'(diff1) : OW'(err);
  assign op_i = cfg_i.incremental_mode ? OW'(err)   : OW'(sum_clamp);
  assign op_d = cfg_i.incremental_mode ? OW'(diff2) : OW'(diff1);
  assign gain_i_eff = sep_off ? '0 : cfg_i.integ_gain;

  // Three gain products, each an unsigned Q8.8 gain times a signed operand
  assign prod_p = $signed({1'b0, cfg_i.prop_gain})  * op_p;
  assign prod_i = $signed({1'b0, gain_i_eff})       * op_i;
  assign prod_d = $signed({1'b0, cfg_i.deriv_gain}) * op_d;

  // Sum and drop the fraction, rounding toward minus infinity
  assign acc    = AW'(prod_p) + AW'(prod_i) + AW'(prod_d);
  assign acc_sh = acc >>> GAIN_FRAC_BITS;
  assign u_raw  = cfg_i.incremental_mode ? (UW'(acc_sh) + UW'(held_i)) : UW'(acc_sh);

  // Output magnitude clamp; equality counts as a hit
  assign u_mag   = u_raw[UW-1] ? UW'(-u_raw) : UW'(u_raw);
  assign out_hit = u_mag >= UW'(cfg_i.output_limit);
  assign lim_s   = $signed({1'b0, cfg_i.output_limit});
  always_comb begin
    if (!out_hit) begin
      drive_full = u_raw[HELD_W-1:0];
    end else if (u_raw[UW-1]) begin
      drive_full = -lim_s;
    end else begin
      drive_full = lim_s;
    end
  end

  // Next state and result fields
  assign error_o            = err;
  assign integral_o         = cfg_i.incremental_mode ? integral_i : sum_clamp;
  assign held_o             = drive_full;
  assign drive_value_o      = DATA_WIDTH'(drive_full);
  assign output_clamped_o   = out_hit;
  assign integral_clamped_o = !cfg_i.incremental_mode && int_hit;

endmodule

`default_nettype wire

@@ rtl/pid_controller_dual_form_core.sv @@
// Top level of the dual-form PID controller: register file, input register,
// controller state and result register. Depends on pidc_pkg, pidc_datapath.
//
//   channel  direction  handshake                  payload
//   s_axis   in         s_axis_tvalid/tready       tdata: setpoint, measurement
//   m_axis   out        m_axis_tvalid/tready       tdata: drive_value
//                                                  tuser: output/integral clamp flags
//   cfg      in         cfg_valid_i/cfg_ready_o    cfg_addr_i, cfg_data_i
//
// One request per cycle is sustained while m_axis_tready is high. A request is
// registered twice: first in the input register, then in the result register,
// which takes it once free and from which the result is valid on m_axis.
// The controller state loop (errors, integral sum, held output) closes through
// the combinational datapath, so each request sees the state its predecessor left.
// A stalled result holds; one more request may wait in the input register.
// Reset clears the state, restores the register defaults and empties both stages.
`default_nettype none

module pid_controller_dual_form_core #(
  parameter int unsigned DATA_WIDTH     = 16,
  parameter int unsigned GAIN_FRAC_BITS = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Request stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [DATA_WIDTH-1:0] setpoint, [2*DATA_WIDTH-1:DATA_WIDTH] measurement
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  // Result stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // [DATA_WIDTH-1:0] drive_value
  output logic [((DATA_WIDTH+7)/8)*8-1:0]        m_axis_tdata,
  // [0] output_clamped, [1] integral_clamped
  output logic [pidc_pkg::TUSER_W-1:0]           m_axis_tuser,
  // Configuration writes
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [pidc_pkg::CFG_ADDR_W-1:0]        cfg_addr_i,
  input  logic [pidc_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import pidc_pkg::*;

  localparam int unsigned EW      = DATA_WIDTH + 1;
  localparam int unsigned OUT_TDW = ((DATA_WIDTH + 7) / 8) * 8;

  cfg_t cfg_q;

  logic                           in_valid_q;
  logic signed [DATA_WIDTH-1:0]   setpoint_q, measurement_q;
  logic                           out_valid_q;
  logic [DATA_WIDTH-1:0]          drive_q;
  logic [TUSER_W-1:0]             flags_q;

  logic signed [EW-1:0]           last_error_q, prev_error_q;
  logic signed [INTEG_W-1:0]      integral_q;
  logic signed [HELD_W-1:0]       held_q;

  logic signed [EW-1:0]           error_d;
  logic signed [INTEG_W-1:0]      integral_d;
  logic signed [HELD_W-1:0]       held_d;
  logic [DATA_WIDTH-1:0]          drive_d;
  logic                           out_clamp_d, int_clamp_d;

  logic                           advance;

  // Pipeline control: the input stage moves on when the result register is free
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  // Configuration register file; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain            <= '0;
      cfg_q.integ_gain           <= '0;
      cfg_q.deriv_gain           <= '0;
      cfg_q.integral_limit       <= '0;
      cfg_q.output_limit         <= OUT_LIM_RST;
      cfg_q.incremental_mode     <= 1'b0;
      cfg_q.separation_enable    <= 1'b0;
      cfg_q.separation_threshold <= SEP_THR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_PROP_GAIN:  cfg_q.prop_gain            <= cfg_data_i[GAIN_W-1:0];
        REG_INTEG_GAIN: cfg_q.integ_gain           <= cfg_data_i[GAIN_W-1:0];
        REG_DERIV_GAIN: cfg_q.deriv_gain           <= cfg_data_i[GAIN_W-1:0];
        REG_INTEG_LIM:  cfg_q.integral_limit       <= cfg_data_i[ILIM_W-1:0];
        REG_OUT_LIM:    cfg_q.output_limit         <= cfg_data_i[OLIM_W-1:0];
        REG_INCR_MODE:  cfg_q.incremental_mode     <= cfg_data_i[0];
        REG_SEP_EN:     cfg_q.separation_enable    <= cfg_data_i[0];
        REG_SEP_THR:    cfg_q.separation_threshold <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      setpoint_q    <= $signed(s_axis_tdata[DATA_WIDTH-1:0]);
      measurement_q <= $signed(s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
    end
  end

  pidc_datapath #(
    .DATA_WIDTH     (DATA_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_datapath (
    .cfg_i              (cfg_q),
    .setpoint_i         (setpoint_q),
    .measurement_i      (measurement_q),
    .last_error_i       (last_error_q),
    .prev_error_i       (prev_error_q),
    .integral_i         (integral_q),
    .held_i             (held_q),
    .error_o            (error_d),
    .integral_o         (integral_d),
    .held_o             (held_d),
    .drive_value_o      (drive_d),
    .output_clamped_o   (out_clamp_d),
    .integral_clamped_o (int_clamp_d)
  );

  // Controller state, updated once per request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_error_q <= '0;
      prev_error_q <= '0;
      integral_q   <= '0;
      held_q       <= '0;
    end else if (advance) begin
      last_error_q <= error_d;
      prev_error_q <= last_error_q;
      integral_q   <= integral_d;
      held_q       <= held_d;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      drive_q                  <= drive_d;
      flags_q[TUSER_OUT_CLAMP] <= out_clamp_d;
      flags_q[TUSER_INT_CLAMP] <= int_clamp_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDW'(drive_q);
  assign m_axis_tuser  = flags_q;

endmodule

`default_nettype wire
